// File: hw/rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NO_QUOTE = 3'd0;
  localparam logic [2:0] ERR_CTRL     = 3'd1;
  localparam logic [2:0] ERR_ESC      = 3'd2;
  localparam logic [2:0] ERR_HEX      = 3'd3;
  localparam logic [2:0] ERR_NO_LOW   = 3'd4;
  localparam logic [2:0] ERR_BAD_LOW  = 3'd5;
  localparam logic [2:0] ERR_EOF      = 3'd6;

  // Entries held between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // One input byte's worth of results: up to four words, emitted from bytes[0].
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    logic [1:0]      kind;
    logic [2:0]      code;
  } jsu_entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/jsu_front.sv
// Front end: string/escape state machine that turns each input byte into a result entry.
`default_nettype none
module jsu_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [7:0]         in_byte,
  input  wire logic               text_end,
  output logic                    push,
  output jsu_pkg::jsu_entry_t     entry
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_STR  = 7'b0000010,
    ST_ESC  = 7'b0000100,
    ST_HEX1 = 7'b0001000,
    ST_BS2  = 7'b0010000,
    ST_U2   = 7'b0100000,
    ST_HEX2 = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hi_r, hi_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [3:0]  hv;
  logic        hv_ok;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;

  function automatic jsu_entry_t one_word(input logic [7:0] b, input logic [1:0] k,
                                          input logic [2:0] c);
    jsu_entry_t e;
    e          = '0;
    e.bytes[0] = b;
    e.kind     = k;
    e.code     = c;
    return e;
  endfunction

  function automatic jsu_entry_t utf8_enc(input logic [20:0] cp);
    jsu_entry_t e;
    e      = '0;
    e.kind = KIND_BYTE;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.last_idx = 2'd1;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.last_idx = 2'd2;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.last_idx = 2'd3;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  always_comb begin
    hv_ok = 1'b1;
    hv    = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hv = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hv = in_byte[3:0] + 4'd9;
    end else begin
      hv_ok = 1'b0;
    end
  end

  assign acc_new = {acc_r[11:0], hv};
  assign pair_cp = 21'h10000 + {1'b0, hi_r, 10'b0} + {11'b0, acc_new[9:0]};

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    entry     = '0;
    if (fire) begin
      if (state_r != ST_IDLE && text_end) begin
        push      = 1'b1;
        entry     = one_word(8'h00, KIND_ERR, ERR_EOF);
        state_nxt = ST_IDLE;
      end else begin
        case (state_r)
          ST_STR: begin
            if (in_byte == 8'h22) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_DONE, ERR_NO_QUOTE);
              state_nxt = ST_IDLE;
            end else if (in_byte[7:5] == 3'b000) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_ERR, ERR_CTRL);
              state_nxt = ST_IDLE;
            end else if (in_byte == 8'h5C) begin
              state_nxt = ST_ESC;
            end else begin
              push  = 1'b1;
              entry = one_word(in_byte, KIND_BYTE, ERR_NO_QUOTE);
            end
          end
          ST_ESC: begin
            state_nxt = ST_STR;
            push      = 1'b1;
            case (in_byte)
              8'h22, 8'h5C, 8'h2F: entry = one_word(in_byte, KIND_BYTE, ERR_NO_QUOTE);
              8'h6E: entry = one_word(8'h0A, KIND_BYTE, ERR_NO_QUOTE);
              8'h72: entry = one_word(8'h0D, KIND_BYTE, ERR_NO_QUOTE);
              8'h74: entry = one_word(8'h09, KIND_BYTE, ERR_NO_QUOTE);
              8'h62: entry = one_word(8'h08, KIND_BYTE, ERR_NO_QUOTE);
              8'h66: entry = one_word(8'h0C, KIND_BYTE, ERR_NO_QUOTE);
              8'h75: begin
                push      = 1'b0;
                state_nxt = ST_HEX1;
                acc_nxt   = '0;
                cnt_nxt   = '0;
              end
              default: begin
                entry     = one_word(8'h00, KIND_ERR, ERR_ESC);
                state_nxt = ST_IDLE;
              end
            endcase
          end
          ST_HEX1, ST_HEX2: begin
            if (!hv_ok) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_ERR, ERR_HEX);
              state_nxt = ST_IDLE;
            end else begin
              acc_nxt = acc_new;
              if (cnt_r != 2'd3) begin
                cnt_nxt = cnt_r + 2'd1;
              end else begin
                cnt_nxt = '0;
                if (state_r == ST_HEX1) begin
                  if (acc_new[15:10] == 6'b110110) begin
                    // high surrogate: keep its payload, expect the low half
                    hi_nxt    = acc_new[9:0];
                    state_nxt = ST_BS2;
                  end else begin
                    push      = 1'b1;
                    entry     = utf8_enc({5'b0, acc_new});
                    state_nxt = ST_STR;
                  end
                end else if (acc_new[15:10] != 6'b110111) begin
                  push      = 1'b1;
                  entry     = one_word(8'h00, KIND_ERR, ERR_BAD_LOW);
                  state_nxt = ST_IDLE;
                end else begin
                  push      = 1'b1;
                  entry     = utf8_enc(pair_cp);
                  state_nxt = ST_STR;
                end
              end
            end
          end
          ST_BS2: begin
            if (in_byte != 8'h5C) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_ERR, ERR_NO_LOW);
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_U2;
            end
          end
          ST_U2: begin
            if (in_byte != 8'h75) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_ERR, ERR_NO_LOW);
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_HEX2;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
          end
          default: begin
            if (text_end || in_byte != 8'h22) begin
              push      = 1'b1;
              entry     = one_word(8'h00, KIND_ERR, ERR_NO_QUOTE);
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_STR;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      hi_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      hi_r    <= hi_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jsu_queue.sv
// Small entry queue that decouples the front end from the output sequencer.
`default_nettype none
module jsu_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire jsu_pkg::jsu_entry_t wr_entry,
  input  wire logic                pop,
  output jsu_pkg::jsu_entry_t      head,
  output logic                     empty,
  output logic                     full
);
  import jsu_pkg::*;

  jsu_entry_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= PTR_W'((32'(wr_ptr_r) + 1) % QUEUE_DEPTH);
      if (pop)  rd_ptr_r <= PTR_W'((32'(rd_ptr_r) + 1) % QUEUE_DEPTH);
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jsu_back.sv
// Back end: unpack queued entries into output words through a registered stage.
`default_nettype none
module jsu_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire jsu_pkg::jsu_entry_t head,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_code,
  output logic                     out_last
);
  import jsu_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic [1:0] kind_r;
  logic [2:0] code_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign load   = !valid_r || out_ready;
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && !empty && at_end;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r <= head.bytes[idx_r];
      kind_r <= head.kind;
      code_r <= head.code;
      last_r <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_code  = code_r;
  assign out_last  = last_r;

`ifndef SYNTH
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r != KIND_BYTE |-> last_r)
    else $error("status word not marked last");
  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r != KIND_BYTE |-> byte_r == 8'h00)
    else $error("status word carries a data byte");
  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("word index not rewound after entry done");
  a_multi_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && head.last_idx != 2'd0 |-> head.kind == KIND_BYTE)
    else $error("multi-word entry with status kind");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8_top.sv
// Top level of the JSON string literal decoder with UTF-8 output.
// Usage:
//   Feed the bytes of a JSON string literal, opening quote first, on the in_
//   stream: in_tdata is the byte, in_tlast marks end of text (byte ignored).
//   Decoded UTF-8 words leave on the out_ stream. out_tuser gives the kind
//   (data byte, string complete, error); out_tdata carries the byte and, for
//   errors, the error code. out_tlast flags the final word caused by one
//   input word. Bytes that only advance the parse (opening quote, backslash, 'u',
//   leading hex digits) cause no output word.
// Timing:
//   One input word per cycle while the queue has room. Each word is classified in
//   the cycle it is accepted and its results (zero to four words) are queued
//   as one entry in a four-entry queue; the output register then presents them
//   in order. The output side moves one word per cycle while out_tready is high,
//   and a \uXXXX escape expanding to three or four bytes is absorbed by the queue.
// Reset (rst_n low, synchronous): the parser waits for an opening quote and
//   the queue and output register are emptied.
// Stall: with out_tready low the output word holds; input is still taken
//   until the queue fills, then in_tready drops.
`default_nettype none
module json_string_unescape_utf8_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // text_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last
);
  import jsu_pkg::*;

  logic       fire;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  jsu_entry_t front_entry;
  jsu_entry_t q_head;
  logic [7:0] o_byte;
  logic [2:0] o_code;

  // Accept a word whenever the queue has room.
  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_tdata),
    .text_end (in_tlast),
    .push     (push),
    .entry    (front_entry)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (front_entry),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (o_byte),
    .out_kind  (out_tuser),
    .out_code  (o_code),
    .out_last  (out_tlast)
  );

  // Pack byte and error code, zero fill to two bytes.
  assign out_tdata = {5'b0, o_code, o_byte};

endmodule
`default_nettype wire

// File: bench/json_string_unescape_utf8_top_test.sv
// Self-checking bench for the JSON string decoder: streamed literals against a UTF-8 predictor.
`timescale 1ns / 100ps
module json_string_unescape_utf8_top_test;
  import jsu_pkg::*;

  // Cycles to wait past the last expected word; cycle count that ends a stuck run.
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 480;

  // Characters that steer the parse.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;

  // Error code field value on words that are not errors.
  localparam logic [2:0] NO_CODE = 3'd0;

  // Parser position, tracked by the predictor.
  typedef enum logic [2:0] {
    P_IDLE, P_STR, P_ESC, P_HEX1, P_BS2, P_U2, P_HEX2
  } parse_t;

  // One input word: text byte plus end-of-text flag.
  typedef struct {
    logic [7:0] data;
    logic       eot;
  } text_word_t;

  // One result word as the predictor sees it.
  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  text_word_t text_q[$];     // words waiting to be sent
  decoded_t   decoded_q[$];  // decoded words not yet seen on the output

  // Predictor state.
  parse_t      pmode = P_IDLE;
  logic [15:0] hex_acc = '0;
  logic [9:0]  hi_bits = '0;
  logic [1:0]  hex_cnt = '0;

  int mismatches = 0;
  int taken_cnt = 0;
  int total_words = 0;
  int cycle = 0;

  // Sender burst bookkeeping, receiver stall pattern.
  int burst_left = 0;
  int gap_left = 0;
  int phase_left = 0;
  int stall_style = 0;

  json_string_unescape_utf8_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // text_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte, [10:8] error_code, rest zero
    .out_tuser  (out_tuser),   // [1:0] kind
    .out_tlast  (out_tlast)    // last
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41 + 8'd10);
    return -1;
  endfunction

  function automatic decoded_t mk_word(input logic [7:0] d, input logic [1:0] k,
                                       input logic [2:0] e);
    decoded_t w;
    w.data = d;
    w.kind = k;
    w.code = e;
    w.last = 1'b0;
    return w;
  endfunction

  // Advance the parser by one accepted word and queue the words it decodes.
  task automatic decode_word(input logic [7:0] c, input logic eot);
    decoded_t    res[$];
    int          h;
    logic        emit_cp;
    logic [20:0] cp;
    emit_cp = 1'b0;
    cp = '0;
    if (pmode != P_IDLE && eot) begin
      // text ended inside the literal, wherever the parse stood
      res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_EOF));
      pmode = P_IDLE;
    end else begin
      case (pmode)
        P_STR: begin
          if (c == CH_QUOTE) begin
            res.insert(res.size(), mk_word(8'h00, KIND_DONE, NO_CODE));
            pmode = P_IDLE;
          end else if (c < 8'h20) begin
            res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_CTRL));
            pmode = P_IDLE;
          end else if (c == CH_BSLASH) begin
            pmode = P_ESC;
          end else begin
            res.insert(res.size(), mk_word(c, KIND_BYTE, NO_CODE));
          end
        end
        P_ESC: begin
          pmode = P_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH:
              res.insert(res.size(), mk_word(c, KIND_BYTE, NO_CODE));
            CH_N: res.insert(res.size(), mk_word(8'h0A, KIND_BYTE, NO_CODE));
            CH_R: res.insert(res.size(), mk_word(8'h0D, KIND_BYTE, NO_CODE));
            CH_T: res.insert(res.size(), mk_word(8'h09, KIND_BYTE, NO_CODE));
            CH_B: res.insert(res.size(), mk_word(8'h08, KIND_BYTE, NO_CODE));
            CH_F: res.insert(res.size(), mk_word(8'h0C, KIND_BYTE, NO_CODE));
            CH_U: begin
              pmode = P_HEX1;
              hex_acc = '0;
              hex_cnt = '0;
            end
            default: begin
              res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_ESC));
              pmode = P_IDLE;
            end
          endcase
        end
        P_HEX1, P_HEX2: begin
          h = hex_val(c);
          if (h < 0) begin
            res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_HEX));
            pmode = P_IDLE;
          end else begin
            hex_acc = {hex_acc[11:0], h[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = '0;
              if (pmode == P_HEX1) begin
                if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                  // high half of a pair: hold its bits, look for the low half
                  hi_bits = hex_acc[9:0];
                  pmode = P_BS2;
                end else begin
                  cp = {5'b0, hex_acc};
                  emit_cp = 1'b1;
                  pmode = P_STR;
                end
              end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_BAD_LOW));
                pmode = P_IDLE;
              end else begin
                cp = 21'h10000 + {1'b0, hi_bits, 10'b0} + {11'b0, hex_acc[9:0]};
                emit_cp = 1'b1;
                pmode = P_STR;
              end
            end
          end
        end
        P_BS2: begin
          if (c != CH_BSLASH) begin
            res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_NO_LOW));
            pmode = P_IDLE;
          end else begin
            pmode = P_U2;
          end
        end
        P_U2: begin
          if (c != CH_U) begin
            res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_NO_LOW));
            pmode = P_IDLE;
          end else begin
            pmode = P_HEX2;
            hex_acc = '0;
            hex_cnt = '0;
          end
        end
        default: begin
          if (eot || c != CH_QUOTE) begin
            res.insert(res.size(), mk_word(8'h00, KIND_ERR, ERR_NO_QUOTE));
            pmode = P_IDLE;
          end else begin
            pmode = P_STR;
          end
        end
      endcase
    end
    // UTF-8 encode a finished code point
    if (emit_cp) begin
      if (cp <= 21'h7F) begin
        res.insert(res.size(), mk_word(cp[7:0], KIND_BYTE, NO_CODE));
      end else if (cp <= 21'h7FF) begin
        res.insert(res.size(), mk_word({3'b110, cp[10:6]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[5:0]}, KIND_BYTE, NO_CODE));
      end else if (cp <= 21'hFFFF) begin
        res.insert(res.size(), mk_word({4'b1110, cp[15:12]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[11:6]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[5:0]}, KIND_BYTE, NO_CODE));
      end else begin
        res.insert(res.size(), mk_word({5'b11110, cp[20:18]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[17:12]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[11:6]}, KIND_BYTE, NO_CODE));
        res.insert(res.size(), mk_word({2'b10, cp[5:0]}, KIND_BYTE, NO_CODE));
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) decoded_q.insert(decoded_q.size(), res[i]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic put_byte(input logic [7:0] b);
    text_word_t w;
    w.data = b;
    w.eot = 1'b0;
    text_q.insert(text_q.size(), w);
  endtask

  // End of text; the byte lane carries junk that must be ignored.
  task automatic put_end();
    text_word_t w;
    w.data = 8'($urandom_range(0, 255));
    w.eot = 1'b1;
    text_q.insert(text_q.size(), w);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  task automatic put_hex(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) put_byte(hex_char(v[i*4 +: 4]));
  endtask

  task automatic put_ucode(input logic [15:0] v);
    put_byte(CH_BSLASH);
    put_byte(CH_U);
    put_hex(v);
  endtask

  // Favor the ends of a code point range.
  function automatic logic [15:0] span_pick(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return 16'($urandom_range(32'(hi), 32'(lo)));
    endcase
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F, CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // One well-formed piece of string content.
  task automatic put_segment();
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0: begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(8'h20, 8'hFF));
        put_byte(b);
      end
      1: begin
        put_byte(CH_BSLASH);
        case ($urandom_range(0, 7))
          0: put_byte(CH_QUOTE);
          1: put_byte(CH_BSLASH);
          2: put_byte(CH_SLASH);
          3: put_byte(CH_N);
          4: put_byte(CH_R);
          5: put_byte(CH_T);
          6: put_byte(CH_B);
          default: put_byte(CH_F);
        endcase
      end
      2: put_ucode(span_pick(16'h0000, 16'h007F));
      3: put_ucode(span_pick(16'h0080, 16'h07FF));
      4: begin
        if ($urandom_range(0, 1)) put_ucode(span_pick(16'h0800, 16'hD7FF));
        else put_ucode(span_pick(16'hE000, 16'hFFFF));
      end
      5: put_ucode(span_pick(16'hDC00, 16'hDFFF));  // lone low half, encoded as is
      default: begin
        put_ucode(span_pick(16'hD800, 16'hDBFF));
        put_ucode(span_pick(16'hDC00, 16'hDFFF));
      end
    endcase
  endtask

  // Break the literal in one of the ways the parser must report.
  task automatic put_fault();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: put_byte(8'($urandom_range(0, 31)));
      1: begin
        put_byte(CH_BSLASH);
        b = 8'($urandom_range(0, 255));
        while (is_escape_letter(b)) b = 8'($urandom_range(0, 255));
        put_byte(b);
      end
      2: begin
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
        b = 8'($urandom_range(0, 255));
        while (hex_val(b) >= 0) b = 8'($urandom_range(0, 255));
        put_byte(b);
      end
      3: begin
        // text ends at some depth of the parse
        case ($urandom_range(0, 4))
          0: ;
          1: put_byte(CH_BSLASH);
          2: begin
            put_byte(CH_BSLASH);
            put_byte(CH_U);
            repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
          end
          3: put_ucode(span_pick(16'hD800, 16'hDBFF));
          default: begin
            put_ucode(span_pick(16'hD800, 16'hDBFF));
            put_byte(CH_BSLASH);
            if ($urandom_range(0, 1)) put_byte(CH_U);
          end
        endcase
        put_end();
      end
      4: begin
        put_ucode(span_pick(16'hD800, 16'hDBFF));
        b = 8'($urandom_range(0, 255));
        while (b == CH_BSLASH) b = 8'($urandom_range(0, 255));
        put_byte(b);
      end
      5: begin
        put_ucode(span_pick(16'hD800, 16'hDBFF));
        put_byte(CH_BSLASH);
        b = 8'($urandom_range(0, 255));
        while (b == CH_U) b = 8'($urandom_range(0, 255));
        put_byte(b);
      end
      default: begin
        put_ucode(span_pick(16'hD800, 16'hDBFF));
        v = 16'($urandom_range(0, 16'hFFFF));
        while (v >= 16'hDC00 && v <= 16'hDFFF) v = 16'($urandom_range(0, 16'hFFFF));
        put_ucode(v);
      end
    endcase
  endtask

  task automatic put_literal();
    int nseg;
    nseg = $urandom_range(0, 6);
    put_byte(CH_QUOTE);
    for (int i = 0; i < nseg; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        put_fault();
        return;
      end
      put_segment();
    end
    if ($urandom_range(0, 15) == 0) put_end();
    else put_byte(CH_QUOTE);
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 5) == 0) put_end();
      else put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- driver

  // Present words in bursts; predict each one on the edge that accepts it.
  always @(posedge clk) begin
    text_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_word(in_tdata, in_tlast);
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (text_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          nxt = text_q.pop_front();
          in_tdata <= nxt.data;
          in_tlast <= nxt.eot;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            // new burst; a third of the time no gap at all
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(10, 25);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Switch stall style at random intervals: open, light, heavy, alternating.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_style = $urandom_range(0, 3);
      phase_left = $urandom_range(20, 120);
    end else begin
      phase_left--;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ~out_tready;
    endcase
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    decoded_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected word: out_tdata %h out_tuser %h out_tlast %b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        exp_w = decoded_q.pop_front();
        if (out_tdata[7:0] !== exp_w.data) begin
          $error("out_byte: expected %h, got %h", exp_w.data, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[10:8] !== exp_w.code) begin
          $error("error_code: expected %0d, got %0d", exp_w.code, out_tdata[10:8]);
          mismatches++;
        end
        if (out_tdata[15:11] !== 5'b0) begin
          $error("out_tdata pad: expected 0, got %h", out_tdata[15:11]);
          mismatches++;
        end
        if (out_tuser !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, out_tuser);
          mismatches++;
        end
        if (out_tlast !== exp_w.last) begin
          $error("last: expected %b, got %b", exp_w.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stop a run that hangs.
  always @(posedge clk) begin
    cycle++;
    if (cycle >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // Directed: waiting faults, raw extremes, a simple escape,
    // the largest surrogate pair, a done, then a control char.
    put_byte(8'h78);
    put_end();
    put_byte(CH_QUOTE);
    put_byte(8'hFF);
    put_byte(8'h20);
    put_byte(CH_BSLASH);
    put_byte(CH_N);
    put_ucode(16'hDBFF);
    put_ucode(16'hDFFF);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    put_byte(8'h00);

    // Random: mostly well-formed literals with random content, some noise.
    while (text_q.size() < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 8) put_literal();
      else put_noise();
    end
    total_words = text_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < total_words) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    // catch any stray words after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
